@@ hw/rtl/imh_pkg.sv @@
package imh_pkg;

  localparam int ID_SPACE      = 1024;
  localparam int ID_W          = 10;
  localparam int KEY_IN_W      = 32;
  localparam int OCC_W         = 11;
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_CHANGE = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_ALREADY     = 3'd3,
    ST_NOT_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_RM_TOP,
    S_RM_LAST,
    S_RM_KEY,
    S_UP_RD,
    S_UP_KEY,
    S_UP_CMP,
    S_DN_L,
    S_DN_LK,
    S_DN_RK,
    S_DN_CMP,
    S_PLACE,
    S_REPLY
  } state_t;

endpackage

@@ hw/rtl/imh_req_if.sv @@
interface imh_req_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic [imh_pkg::ID_W-1:0]     element_id;
  logic [imh_pkg::KEY_IN_W-1:0] key_value;

  modport source(output valid, kind, element_id, key_value, input ready);
  modport sink(input valid, kind, element_id, key_value, output ready);
endinterface

@@ hw/rtl/imh_rsp_if.sv @@
interface imh_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [imh_pkg::ID_W-1:0]     popped_id;
  logic [imh_pkg::KEY_IN_W-1:0] popped_key;
  logic                         present;
  logic [imh_pkg::OCC_W-1:0]    occupancy;
  logic [2:0]                   status;

  modport source(output valid, popped_id, popped_key, present, occupancy, status,
                 input ready);
  modport sink(input valid, popped_id, popped_key, present, occupancy, status,
               output ready);
endinterface

@@ hw/rtl/imh_ram.sv @@
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/imh_key_cmp.sv @@
module imh_key_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  output logic                 lt
);
  // unsigned strict less-than; equal keys never move an entry
  assign lt = (a < b);
endmodule

@@ hw/rtl/indexed_min_heap.sv @@
// Indexed binary min-heap of 10-bit identifiers ordered by a KEY_WIDTH-bit
// unsigned key. One operation per request transaction, one response
// transaction per request: clear, insert, change key, remove minimum and
// membership query. Requests are taken only while the block is idle; a
// response holds until taken, then the next request is accepted. Each
// operation does a lookup and a decision; sift up then, level by level,
// reads the parent slot and its key and compares in the shared comparator,
// and sift down reads both child slots and keys and compares each against
// the best so far. Remove minimum first drops the top and fetches the last
// slot. Clear sweeps the 1024-entry position map, one entry a cycle; the
// same clearing pass runs after reset, during which no request is accepted.
module indexed_min_heap #(
  parameter int CAPACITY  = imh_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = imh_pkg::DEF_KEY_WIDTH
) (
  input logic      clk,
  input logic      rst,
  imh_req_if.sink  req,
  imh_rsp_if.source rsp
);
  import imh_pkg::*;

  localparam int SW = $clog2(CAPACITY);       // heap slot index width
  localparam int CW = $clog2(CAPACITY + 1);   // entry count width
  localparam int PW = SW + 1;                 // position map entry: present + slot

  state_t state, state_next;

  // operation registers
  logic [2:0]           op_kind, op_kind_next;
  logic [ID_W-1:0]      op_id, op_id_next;
  logic [KEY_WIDTH-1:0] op_key, op_key_next;

  // sift registers: hole slot, moving entry, children seen this level
  logic [SW-1:0]        s, s_next;
  logic [ID_W-1:0]      mid, mid_next;
  logic [KEY_WIDTH-1:0] mkey, mkey_next;
  logic [ID_W-1:0]      lid, lid_next;
  logic [ID_W-1:0]      rid, rid_next;
  logic [KEY_WIDTH-1:0] lkey, lkey_next;
  logic                 take_l, take_l_next;

  logic [CW-1:0]        count, count_next;
  logic [ID_W-1:0]      clr_idx, clr_idx_next;
  logic                 clr_reply, clr_reply_next;

  // response registers
  logic [ID_W-1:0]      o_pid, o_pid_next;
  logic [KEY_WIDTH-1:0] o_pkey, o_pkey_next;
  logic                 o_pres, o_pres_next;
  status_t              o_status, o_status_next;

  // memory ports
  logic                 h_we, p_we, k_we;
  logic [SW-1:0]        h_wa, h_ra;
  logic [ID_W-1:0]      h_wd, h_rd;
  logic [ID_W-1:0]      p_wa, p_ra;
  logic [PW-1:0]        p_wd, p_rd;
  logic [ID_W-1:0]      k_wa, k_ra;
  logic [KEY_WIDTH-1:0] k_wd, k_rd;

  // shared comparator
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;

  logic [63:0]          key_in_wide, pkey_wide;
  logic [KEY_WIDTH-1:0] key_in;
  logic [SW+1:0]        lw, rw, cnt_x;
  logic [SW-1:0]        parent;

  imh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  imh_ram #(.WIDTH(PW), .DEPTH(ID_SPACE)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );
  imh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ID_SPACE)) u_key (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );
  imh_key_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt));

  // keep the low KEY_WIDTH bits of the incoming key
  assign key_in_wide = 64'(req.key_value);
  assign key_in      = key_in_wide[KEY_WIDTH-1:0];

  // child and parent slots of the hole
  assign lw     = {1'b0, s, 1'b1};
  assign rw     = lw + (SW+2)'(1);
  assign cnt_x  = (SW+2)'(count);
  assign parent = (s - SW'(1)) >> 1;

  // handshake and response payload
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = (state == S_REPLY);
  assign pkey_wide      = 64'(o_pkey);
  assign rsp.popped_id  = o_pid;
  assign rsp.popped_key = pkey_wide[KEY_IN_W-1:0];
  assign rsp.present    = o_pres;
  assign rsp.occupancy  = OCC_W'(count);
  assign rsp.status     = o_status;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == ID_W'(ID_SPACE - 1)) begin
          state_next = clr_reply ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.kind == KIND_CLEAR) ? S_CLEAR : S_LOOK;
        end
      end
      S_LOOK: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_REPLY;
        case (op_kind)
          KIND_INSERT: begin
            if (!p_rd[SW] && count != CW'(CAPACITY)) state_next = S_UP_RD;
          end
          KIND_CHANGE: begin
            if (p_rd[SW]) state_next = cmp_lt ? S_UP_RD : S_DN_L;
          end
          KIND_REMOVE: begin
            if (count != '0) state_next = S_RM_TOP;
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_RM_TOP:  state_next = S_RM_LAST;
      S_RM_LAST: state_next = (count == '0) ? S_REPLY : S_RM_KEY;
      S_RM_KEY:  state_next = S_DN_L;
      S_UP_RD:   state_next = (s == '0) ? S_PLACE : S_UP_KEY;
      S_UP_KEY:  state_next = S_UP_CMP;
      S_UP_CMP:  state_next = cmp_lt ? S_UP_RD : S_PLACE;
      S_DN_L:    state_next = (lw >= cnt_x) ? S_PLACE : S_DN_LK;
      S_DN_LK:   state_next = S_DN_RK;
      S_DN_RK:   state_next = S_DN_CMP;
      S_DN_CMP: begin
        state_next = ((rw < cnt_x && cmp_lt) || take_l) ? S_DN_L : S_PLACE;
      end
      S_PLACE:   state_next = S_REPLY;
      S_REPLY: begin
        if (rsp.ready) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_kind_next   = op_kind;
    op_id_next     = op_id;
    op_key_next    = op_key;
    s_next         = s;
    mid_next       = mid;
    mkey_next      = mkey;
    lid_next       = lid;
    rid_next       = rid;
    lkey_next      = lkey;
    take_l_next    = take_l;
    count_next     = count;
    clr_idx_next   = clr_idx;
    clr_reply_next = clr_reply;
    o_pid_next     = o_pid;
    o_pkey_next    = o_pkey;
    o_pres_next    = o_pres;
    o_status_next  = o_status;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
    cmp_a = mkey;
    cmp_b = k_rd;
    case (state)
      S_CLEAR: begin
        // wipe one position map entry a cycle
        p_we         = 1'b1;
        p_wa         = clr_idx;
        clr_idx_next = clr_idx + ID_W'(1);
      end
      S_IDLE: begin
        if (req.valid) begin
          op_kind_next  = req.kind;
          op_id_next    = req.element_id;
          op_key_next   = key_in;
          o_pid_next    = '0;
          o_pkey_next   = '0;
          o_pres_next   = 1'b0;
          o_status_next = ST_OK;
          if (req.kind == KIND_CLEAR) begin
            count_next     = '0;
            clr_idx_next   = '0;
            clr_reply_next = 1'b1;
          end
        end
      end
      S_LOOK: begin
        p_ra = op_id;
        k_ra = op_id;
        h_ra = '0;
      end
      S_DECIDE: begin
        cmp_a = op_key;
        case (op_kind)
          KIND_INSERT: begin
            if (p_rd[SW]) begin
              o_status_next = ST_ALREADY;
            end else if (count == CW'(CAPACITY)) begin
              o_status_next = ST_FULL;
            end else begin
              k_we       = 1'b1;
              k_wa       = op_id;
              k_wd       = op_key;
              s_next     = SW'(count);
              count_next = count + CW'(1);
              mid_next   = op_id;
              mkey_next  = op_key;
            end
          end
          KIND_CHANGE: begin
            if (!p_rd[SW]) begin
              o_status_next = ST_NOT_PRESENT;
            end else begin
              k_we      = 1'b1;
              k_wa      = op_id;
              k_wd      = op_key;
              s_next    = p_rd[SW-1:0];
              mid_next  = op_id;
              mkey_next = op_key;
            end
          end
          KIND_REMOVE: begin
            if (count == '0) begin
              o_status_next = ST_EMPTY;
            end else begin
              o_pid_next = h_rd;
            end
          end
          KIND_QUERY: o_pres_next = p_rd[SW];
          default: o_pres_next = 1'b0;
        endcase
      end
      S_RM_TOP: begin
        // drop the minimum from the map, fetch its key and the last slot
        k_ra       = o_pid;
        h_ra       = SW'(count - CW'(1));
        p_we       = 1'b1;
        p_wa       = o_pid;
        p_wd       = '0;
        count_next = count - CW'(1);
      end
      S_RM_LAST: begin
        o_pkey_next = k_rd;
        mid_next    = h_rd;
        k_ra        = h_rd;
      end
      S_RM_KEY: begin
        mkey_next = k_rd;
        s_next    = '0;
      end
      S_UP_RD: begin
        h_ra = parent;
      end
      S_UP_KEY: begin
        lid_next = h_rd;
        k_ra     = h_rd;
      end
      S_UP_CMP: begin
        // parent key above moving key: pull parent down into the hole
        if (cmp_lt) begin
          h_we   = 1'b1;
          h_wa   = s;
          h_wd   = lid;
          p_we   = 1'b1;
          p_wa   = lid;
          p_wd   = {1'b1, s};
          s_next = parent;
        end
      end
      S_DN_L: begin
        h_ra = lw[SW-1:0];
      end
      S_DN_LK: begin
        lid_next = h_rd;
        k_ra     = h_rd;
        h_ra     = rw[SW-1:0];
      end
      S_DN_RK: begin
        lkey_next   = k_rd;
        rid_next    = h_rd;
        k_ra        = h_rd;
        cmp_a       = k_rd;
        cmp_b       = mkey;
        take_l_next = cmp_lt;
      end
      S_DN_CMP: begin
        // pick the smaller child, right only when strictly below the best
        cmp_a = k_rd;
        cmp_b = take_l ? lkey : mkey;
        if (rw < cnt_x && cmp_lt) begin
          h_we   = 1'b1;
          h_wa   = s;
          h_wd   = rid;
          p_we   = 1'b1;
          p_wa   = rid;
          p_wd   = {1'b1, s};
          s_next = rw[SW-1:0];
        end else if (take_l) begin
          h_we   = 1'b1;
          h_wa   = s;
          h_wd   = lid;
          p_we   = 1'b1;
          p_wa   = lid;
          p_wd   = {1'b1, s};
          s_next = lw[SW-1:0];
        end
      end
      S_PLACE: begin
        // settle the moving entry into the hole
        h_we = 1'b1;
        h_wa = s;
        h_wd = mid;
        p_we = 1'b1;
        p_wa = mid;
        p_wd = {1'b1, s};
      end
      S_REPLY: begin
        clr_reply_next = 1'b0;
      end
      default: clr_reply_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      clr_idx   <= clr_idx_next;
      clr_reply <= clr_reply_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind  <= op_kind_next;
    op_id    <= op_id_next;
    op_key   <= op_key_next;
    s        <= s_next;
    mid      <= mid_next;
    mkey     <= mkey_next;
    lid      <= lid_next;
    rid      <= rid_next;
    lkey     <= lkey_next;
    take_l   <= take_l_next;
    o_pid    <= o_pid_next;
    o_pkey   <= o_pkey_next;
    o_pres   <= o_pres_next;
    o_status <= o_status_next;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request and response open together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && o_status == ST_EMPTY) |-> (count == '0))
    else $error("empty status with entries held");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");
endmodule

@@ test/testbench.sv @@
module testbench;
  import imh_pkg::*;

  localparam int HEAP_CAP = DEF_CAPACITY;

  typedef struct packed {
    logic [ID_W-1:0]     popped_id;
    logic [KEY_IN_W-1:0] popped_key;
    logic                present;
    logic [OCC_W-1:0]    occupancy;
    logic [2:0]          status;
  } heap_reply_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [ID_W-1:0]     element_id;
    logic [KEY_IN_W-1:0] key_value;
    logic                typed;
    heap_reply_t         reply;
  } heap_op_t;

  logic clk;
  logic rst;

  imh_req_if req ();
  imh_rsp_if rsp ();

  indexed_min_heap dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow heap: slot array, id -> slot map, per-id key and live count.
  logic [ID_W-1:0]     shadow_slot[HEAP_CAP];
  int                  shadow_pos[ID_SPACE];
  bit                  shadow_live[ID_SPACE];
  logic [KEY_IN_W-1:0] shadow_key[ID_SPACE];
  int                  shadow_count;

  heap_reply_t replies_due[$];
  heap_op_t    pending_typed[$];
  int          mismatches;
  int          sender_idle;
  int          receiver_idle;
  bit          hold_off;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [KEY_IN_W-1:0] key_at(int s);
    return shadow_key[shadow_slot[s]];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [ID_W-1:0] t;
    t = shadow_slot[a];
    shadow_slot[a] = shadow_slot[b];
    shadow_slot[b] = t;
    shadow_pos[shadow_slot[a]] = a;
    shadow_pos[shadow_slot[b]] = b;
  endfunction

  // Ties never move a parent below its child.
  function automatic void bubble_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (key_at(p) > key_at(s)) begin
        swap_entries(p, s);
        s = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int s);
    int m;
    forever begin
      m = s;
      if (2 * s + 1 < shadow_count && key_at(2 * s + 1) < key_at(m)) m = 2 * s + 1;
      if (2 * s + 2 < shadow_count && key_at(2 * s + 2) < key_at(m)) m = 2 * s + 2;
      if (m == s) break;
      swap_entries(s, m);
      s = m;
    end
  endfunction

  // Apply one operation to the shadow heap and return the reply it earns.
  function automatic heap_reply_t apply_heap_op(heap_op_t op);
    heap_reply_t r;
    logic [KEY_IN_W-1:0] old_key;
    int top;
    r = '0;
    r.status = ST_OK;
    case (op.kind)
      KIND_CLEAR: begin
        foreach (shadow_live[i]) shadow_live[i] = 1'b0;
        shadow_count = 0;
      end
      KIND_INSERT: begin
        if (shadow_live[op.element_id]) begin
          r.status = ST_ALREADY;
        end else if (shadow_count >= HEAP_CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[op.element_id] = op.key_value;
          shadow_slot[shadow_count] = op.element_id;
          shadow_pos[op.element_id] = shadow_count;
          shadow_live[op.element_id] = 1'b1;
          shadow_count++;
          bubble_up(shadow_count - 1);
        end
      end
      KIND_CHANGE: begin
        if (!shadow_live[op.element_id]) begin
          r.status = ST_NOT_PRESENT;
        end else begin
          old_key = shadow_key[op.element_id];
          shadow_key[op.element_id] = op.key_value;
          if (op.key_value < old_key) bubble_up(shadow_pos[op.element_id]);
          else bubble_down(shadow_pos[op.element_id]);
        end
      end
      KIND_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top = shadow_slot[0];
          r.popped_id = ID_W'(top);
          r.popped_key = shadow_key[top];
          swap_entries(0, shadow_count - 1);
          shadow_live[top] = 1'b0;
          shadow_count--;
          bubble_down(0);
        end
      end
      KIND_QUERY: r.present = shadow_live[op.element_id];
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Predict on every accepted request, check on every accepted response.
  // Typed rows override the predicted reply but still advance the shadow state.
  always @(posedge clk) begin
    heap_reply_t want, seen, guess;
    heap_op_t    op;
    if (!rst && rsp.valid && rsp.ready) begin
      seen = '{rsp.popped_id, rsp.popped_key, rsp.present, rsp.occupancy, rsp.status};
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", seen);
      end else begin
        want = replies_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, seen);
        end
      end
    end
    if (!rst && req.valid && req.ready) begin
      op = '{req.kind, req.element_id, req.key_value, 1'b0, '0};
      guess = apply_heap_op(op);
      if (pending_typed.size() > 0) begin
        if (pending_typed[0].typed) guess = pending_typed[0].reply;
        void'(pending_typed.pop_front());
      end
      replies_due = {replies_due, guess};
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp.ready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // Present one transaction, idling first at random; returns after acceptance.
  task automatic send_op(heap_op_t op, bit track);
    while ($urandom_range(99) < sender_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    if (track) pending_typed = {pending_typed, op};
    req.valid      <= 1'b1;
    req.kind       <= op.kind;
    req.element_id <= op.element_id;
    req.key_value  <= op.key_value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic heap_op_t make_op(logic [2:0] k, int id, logic [KEY_IN_W-1:0] key);
    return '{k, id[ID_W-1:0], key, 1'b0, '0};
  endfunction

  function automatic heap_op_t typed_op(logic [2:0] k, int id, logic [KEY_IN_W-1:0] key,
                                        bit pres, int occ, logic [2:0] st);
    heap_op_t op;
    op = make_op(k, id, key);
    op.typed = 1'b1;
    op.reply = '{'0, '0, pres, occ[OCC_W-1:0], st};
    return op;
  endfunction

  // Mostly a small id pool so that change and query hit live entries.
  function automatic heap_op_t random_op();
    int roll, id;
    logic [KEY_IN_W-1:0] key;
    logic [2:0] k;
    roll = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? $urandom_range(ID_SPACE - 1) : $urandom_range(23);
    key = ($urandom_range(2) == 0) ? $urandom_range(15) : $urandom;
    if (roll < 1)       k = KIND_CLEAR;
    else if (roll < 40) k = KIND_INSERT;
    else if (roll < 62) k = KIND_CHANGE;
    else if (roll < 85) k = KIND_REMOVE;
    else if (roll < 97) k = KIND_QUERY;
    else                k = 3'($urandom_range(7, 5));
    return make_op(k, id, key);
  endfunction

  heap_op_t directed[] = '{
    typed_op(KIND_QUERY,  0,    32'h0,        1'b0, 0, ST_OK),
    typed_op(KIND_REMOVE, 0,    32'h0,        1'b0, 0, ST_EMPTY),
    typed_op(KIND_CHANGE, 5,    32'h9,        1'b0, 0, ST_NOT_PRESENT),
    typed_op(KIND_INSERT, 1023, 32'hFFFFFFFF, 1'b0, 1, ST_OK),
    typed_op(KIND_INSERT, 1023, 32'h0,        1'b0, 1, ST_ALREADY),
    typed_op(KIND_QUERY,  1023, 32'h0,        1'b1, 1, ST_OK),
    make_op(KIND_INSERT, 0,   32'h0),
    make_op(KIND_INSERT, 512, 32'h0),
    make_op(KIND_INSERT, 341, 32'h7),
    make_op(KIND_CHANGE, 1023, 32'h3),
    make_op(KIND_CHANGE, 0,   32'h0),
    make_op(KIND_CHANGE, 512, 32'h64),
    typed_op(3'd5, 5, 32'h1, 1'b0, 4, ST_OK),
    typed_op(3'd6, 5, 32'h1, 1'b0, 4, ST_OK),
    typed_op(3'd7, 5, 32'h1, 1'b0, 4, ST_OK),
    make_op(KIND_REMOVE, 0, 32'h0),
    make_op(KIND_REMOVE, 0, 32'h0),
    make_op(KIND_REMOVE, 0, 32'h0),
    make_op(KIND_REMOVE, 0, 32'h0),
    typed_op(KIND_REMOVE, 0, 32'h0, 1'b0, 0, ST_EMPTY),
    make_op(KIND_INSERT, 682, 32'h55555555),
    make_op(KIND_INSERT, 341, 32'hAAAAAAAA),
    typed_op(KIND_CLEAR, 0,   32'h0, 1'b0, 0, ST_OK),
    typed_op(KIND_QUERY, 682, 32'h0, 1'b0, 0, ST_OK)
  };

  int idle_plan[3][2] = '{'{29, 70}, '{70, 29}, '{0, 0}};
  int wait_cycles;

  initial begin
    foreach (shadow_live[i]) shadow_live[i] = 1'b0;
    shadow_count   = 0;
    mismatches     = 0;
    sender_idle    = 0;
    receiver_idle  = 0;
    hold_off       = 1'b0;
    req.valid      <= 1'b0;
    req.kind       <= KIND_CLEAR;
    req.element_id <= '0;
    req.key_value  <= '0;
    rst            <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the post-reset clearing pass is absorbed by the handshake.
    foreach (directed[i]) send_op(directed[i], 1'b1);

    foreach (idle_plan[p]) begin
      sender_idle   = idle_plan[p][0];
      receiver_idle = idle_plan[p][1];
      for (int n = 0; n < 135; n++) begin
        // Stall the response side for a long stretch while the next request waits.
        if (p == 0 && n == 40) hold_off = 1'b1;
        send_op(random_op(), 1'b1);
      end
    end
    req.valid <= 1'b0;

    // Drain outstanding replies, then allow the block's latency to pass.
    wait_cycles = 0;
    while (replies_due.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
